>>> rtl/ssq_pkg.sv
// shared types and constants of the stable sorted priority queue
package ssq_pkg;

    localparam int CAPACITY      = 256;
    localparam int HANDLE_BITS   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int OCC_W         = 9;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } mode_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]   handle;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctl_t;

endpackage

>>> rtl/ssq_cell.sv
// one storage cell of the sorted row: compare against the new word and shift by one place
module ssq_cell (
    input  logic              aclk,
    input  ssq_pkg::cell_ctl_t ctl,
    input  ssq_pkg::entry_t   new_entry,
    input  logic              in_use,
    input  logic              prev_keep,
    input  ssq_pkg::entry_t   prev_entry,
    input  ssq_pkg::entry_t   next_entry,
    output ssq_pkg::entry_t   entry,
    output logic              keep
);
    import ssq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // held entry stays ahead of the new word when its priority is not greater
    assign keep  = in_use && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.pop) begin
            entry_next = next_entry;
        end else if (ctl.ins && !keep) begin
            if (prev_keep) begin
                entry_next = new_entry;
            end else begin
                entry_next = prev_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/stable_sorted_priority_queue.sv
// top level of the stable sorted priority queue: row of cells, fill count, result register
//
// usage:
//   s_ channel carries one word per item: s_mode (0 insert, 1 pop),
//   s_task_handle and s_task_priority (both ignored on pop)
//   m_ channel returns exactly one word per item: popped handle and
//   priority (zero unless popped), a status code and the occupancy after
//   the item
//   entries sit in a row of CAPACITY cells sorted by ascending priority;
//   equal priorities keep arrival order, the new word lands behind them
//   every cell compares with the broadcast word and shifts one place in
//   the same cycle, so a new word is taken every cycle unless a stalled
//   result holds s_ready low; the result shows on m_ the cycle after acceptance
//   throughput is set by the compare path of one cell plus the fill count
//   reset (aresetn low, synchronous) empties the queue through the fill
//   count and drops any pending result; cell contents are not cleared
//   when the receiver stalls the result holds in its register and s_ready
//   drops until it is taken, so nothing is lost
module stable_sorted_priority_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [ssq_pkg::HANDLE_BITS-1:0]   s_task_handle,
    input  logic [ssq_pkg::PRIORITY_BITS-1:0] s_task_priority,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ssq_pkg::HANDLE_BITS-1:0]   m_out_handle,
    output logic [ssq_pkg::PRIORITY_BITS-1:0] m_out_priority,
    output logic [ssq_pkg::STATUS_W-1:0]      m_status,
    output logic [ssq_pkg::OCC_W-1:0]         m_occupancy
);
    import ssq_pkg::*;

    // fill count: cells below it hold live entries
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [HANDLE_BITS-1:0]   handle_reg;
    logic [HANDLE_BITS-1:0]   handle_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    logic      accept;
    logic      is_pop;
    logic      is_full;
    logic      is_empty;
    cell_ctl_t ctl;
    entry_t    new_entry;

    entry_t cell_entry [CAPACITY];
    logic   cell_keep  [CAPACITY];

    // result slot frees when empty or when the receiver takes the word
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_pop   = (mode_t'(s_mode) == MODE_POP);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // rejected items leave the row untouched
    assign ctl.ins = accept && !is_pop && !is_full;
    assign ctl.pop = accept && is_pop && !is_empty;

    assign new_entry.handle = s_task_handle;
    assign new_entry.prio   = s_task_priority;

    // the row of cells; the head cell sees an always-kept neighbor so a
    // word that sorts first lands in it
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_k;
        logic   used;

        assign used = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign prev_e = cell_entry[i];
            assign prev_k = 1'b1;
        end else begin : g_body
            assign prev_e = cell_entry[i-1];
            assign prev_k = cell_keep[i-1];
        end

        // the tail cell refills with stale data on pop; the count hides it
        if (i == CAPACITY - 1) begin : g_tail
            assign next_e = cell_entry[i];
        end else begin : g_mid
            assign next_e = cell_entry[i+1];
        end

        ssq_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .in_use     (used),
            .prev_keep  (prev_k),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // result word built from the state seen at acceptance
    always_comb begin
        m_valid_next = m_valid_reg;
        handle_next  = handle_reg;
        prio_next    = prio_reg;
        status_next  = status_reg;
        occ_next     = occ_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            handle_next  = '0;
            prio_next    = '0;
            occ_next     = OCC_W'(count_next);
            if (is_pop) begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next = ST_POPPED;
                    handle_next = cell_entry[0].handle;
                    prio_next   = cell_entry[0].prio;
                end
            end else begin
                status_next = is_full ? ST_FULL : ST_INSERTED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        prio_reg   <= prio_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_handle   = handle_reg;
    assign m_out_priority = prio_reg;
    assign m_status       = status_reg;
    assign m_occupancy    = occ_reg;

`ifndef SYNTHESIS
    // fill count never runs past the row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // an accepted insert into a non-full queue grows the count by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_pop && !is_full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    // a pop on an empty queue reports empty with zero payload
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_pop && is_empty |=>
            m_valid && m_status == ST_EMPTY && m_out_handle == '0 && m_occupancy == '0)
        else $error("pop on empty not reported");

    // a popped word is never worse than the entry left at the head
    a_pop_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ctl.pop) && count_reg != '0 && !$past(accept, 2) |->
            $past(cell_entry[0].prio) <= cell_entry[0].prio)
        else $error("head order broken after pop");
`endif

endmodule
